// ----- rtl/core/swm_pkg.sv -----
// Package for the sliding window median filter.
// Holds default sizes, the configuration register layout and the cell control type.
// No dependencies.
package swm_pkg;

  // Default sizes of the filter.
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned MAX_WINDOW_DEF   = 32;

  // The window size register.
  localparam int unsigned CFG_W = 6;
  localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(3);

  // Control flags that the top level hands to every cell in each cycle.
  typedef struct packed {
    logic accept;   // a sample transaction completes this cycle
    logic full;     // the window holds window-size entries before this sample
    logic valid;    // this cell holds an entry before removal
    logic valid_c;  // this cell holds an entry after the oldest one is removed
    logic shift;    // the removed entry sits at or left of this cell
    logic first;    // this is the leftmost cell
  } swm_cell_ctl_t;

endpackage

// ----- rtl/core/swm_if.sv -----
// Stream interfaces of the sliding window median filter.
// One carries input samples, the other carries median results; both use valid/ready.
// Depends on swm_pkg.
interface swm_sample_if import swm_pkg::*; #(
  parameter int unsigned SampleWidth = SAMPLE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface swm_median_if import swm_pkg::*; #(
  parameter int unsigned SampleWidth = SAMPLE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink (input valid, input median, output ready);
endinterface

// ----- rtl/core/sliding_window_median.sv -----
// Sliding window median filter. Signed samples arrive one transaction at a time and the
// last window-size samples are kept sorted in a row of cells, equal values in arrival
// order. Once the window has filled, every sample yields the lower median, the entry at
// sorted rank (window_size-1)/2; before that no result is given. A sample is taken in
// every clock cycle that input is not held off: the whole cell row removes the oldest
// entry and inserts the new sample at once, set by one compare per cell and a log-depth
// prefix over the removal flags. The median appears in the output register in the cycle
// after the sample transaction; input is held off only while that register holds an
// untaken result. Writing window_size empties the window, so results resume once it
// has refilled. Top level of the filter; instantiates swm_cell and uses swm_pkg and the
// stream interfaces from swm_if.
module sliding_window_median import swm_pkg::*; #(
  parameter int unsigned MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  swm_sample_if.sink        sample_i,
  swm_median_if.source      median_o
);

  localparam int unsigned AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned WIN_W = $clog2(MAX_WINDOW + 1);

  logic [CFG_W-1:0] win_q;
  logic [WIN_W-1:0] fill_q, fill_d;
  logic [WIN_W-1:0] win_eff;
  logic [WIN_W-1:0] fill_c;
  logic [WIN_W-1:0] fill_n;
  logic [AGE_W-1:0] oldest_age;
  logic [AGE_W-1:0] med_idx;
  logic             full;
  logic             accept;
  logic             result;

  logic                           med_valid_q, med_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] med_q;

  swm_cell_ctl_t                  ctl      [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] cur_val  [MAX_WINDOW];
  logic        [AGE_W-1:0]        cur_age  [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] cmp_val  [MAX_WINDOW];
  logic        [AGE_W-1:0]        cmp_age  [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] nxt_val  [MAX_WINDOW];
  logic        [MAX_WINDOW-1:0]   le;
  logic        [MAX_WINDOW-1:0]   del;
  logic        [MAX_WINDOW-1:0]   shift;

  // Effective window: zero acts as one, anything above the row length as the row length.
  always_comb begin
    if (win_q == '0) begin
      win_eff = WIN_W'(1);
    end else if (32'(win_q) > 32'(MAX_WINDOW)) begin
      win_eff = WIN_W'(MAX_WINDOW);
    end else begin
      win_eff = WIN_W'(win_q);
    end
  end

  assign oldest_age = AGE_W'(win_eff - WIN_W'(1));
  assign med_idx    = AGE_W'((win_eff - WIN_W'(1)) >> 1);
  assign full       = (fill_q == win_eff);
  assign fill_c     = full ? (fill_q - WIN_W'(1)) : fill_q;
  assign fill_n     = fill_c + WIN_W'(1);

  // Handshake: a new sample is taken whenever the output register is free or draining.
  assign sample_i.ready = !med_valid_q || median_o.ready;
  assign accept         = sample_i.valid && sample_i.ready;
  assign result         = accept && (fill_n == win_eff);

  // Mark every cell at or right of the removed entry, in log steps.
  always_comb begin
    shift = del;
    for (int s = 1; s < int'(MAX_WINDOW); s = s * 2) begin
      shift = shift | (shift << s);
    end
  end

  // The row of cells.
  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] right_val, left_val;
    logic        [AGE_W-1:0]        right_age, left_age;
    logic                           left_le;

    assign ctl[k].accept  = accept;
    assign ctl[k].full    = full;
    assign ctl[k].valid   = (WIN_W'(k) < fill_q);
    assign ctl[k].valid_c = (WIN_W'(k) < fill_c);
    assign ctl[k].shift   = shift[k];
    assign ctl[k].first   = (k == 0);

    if (k + 1 < MAX_WINDOW) begin : g_right
      assign right_val = cur_val[k+1];
      assign right_age = cur_age[k+1];
    end else begin : g_last
      assign right_val = cur_val[k];
      assign right_age = cur_age[k];
    end

    if (k > 0) begin : g_left
      assign left_val = cmp_val[k-1];
      assign left_age = cmp_age[k-1];
      assign left_le  = le[k-1];
    end else begin : g_head
      assign left_val = '0;
      assign left_age = '0;
      assign left_le  = 1'b0;
    end

    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .AGE_W        (AGE_W)
    ) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl[k]),
      .sample_i     (sample_i.sample),
      .oldest_age_i (oldest_age),
      .right_val_i  (right_val),
      .right_age_i  (right_age),
      .left_val_i   (left_val),
      .left_age_i   (left_age),
      .left_le_i    (left_le),
      .value_o      (cur_val[k]),
      .age_o        (cur_age[k]),
      .del_o        (del[k]),
      .cmp_val_o    (cmp_val[k]),
      .cmp_age_o    (cmp_age[k]),
      .le_o         (le[k]),
      .next_val_o   (nxt_val[k])
    );
  end

  // Fill count: cleared by a window size write, advanced by each sample until full.
  always_comb begin
    fill_d = fill_q;
    if (cfg_we_i) begin
      fill_d = '0;
    end else if (accept) begin
      fill_d = fill_n;
    end
  end

  // Output register valid flag.
  always_comb begin
    med_valid_d = med_valid_q;
    if (median_o.ready) begin
      med_valid_d = 1'b0;
    end
    if (result) begin
      med_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= WIN_RESET;
      fill_q      <= '0;
      med_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      fill_q      <= fill_d;
      med_valid_q <= med_valid_d;
    end
  end

  // Median payload, taken from the row's next contents.
  always_ff @(posedge clk_i) begin
    if (result) begin
      med_q <= nxt_val[med_idx];
    end
  end

  assign median_o.valid  = med_valid_q;
  assign median_o.median = med_q;

  // The window never holds more entries than its size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= win_eff)
    else $error("fill count exceeds window size");

  // At most one entry is removed per sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(del))
    else $error("more than one entry marked for removal");

  // A full window always finds exactly one oldest entry to remove.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (accept && full) |-> $onehot(del))
    else $error("full window without a unique oldest entry");

  // A new result appears only after a sample transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $rose(med_valid_q) |-> $past(accept))
    else $error("result raised without a sample transaction");

endmodule

// ----- rtl/core/swm_cell.sv -----
// One cell of the sorted window: holds one sample and its age.
// Drops the oldest entry and inserts the new sample from neighbor and shared inputs.
// Depends on swm_pkg.
module swm_cell import swm_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned AGE_W        = 5
) (
  input  logic                           clk_i,
  input  swm_cell_ctl_t                  ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic        [AGE_W-1:0]        oldest_age_i,
  input  logic signed [SAMPLE_WIDTH-1:0] right_val_i,
  input  logic        [AGE_W-1:0]        right_age_i,
  input  logic signed [SAMPLE_WIDTH-1:0] left_val_i,
  input  logic        [AGE_W-1:0]        left_age_i,
  input  logic                           left_le_i,
  output logic signed [SAMPLE_WIDTH-1:0] value_o,
  output logic        [AGE_W-1:0]        age_o,
  output logic                           del_o,
  output logic signed [SAMPLE_WIDTH-1:0] cmp_val_o,
  output logic        [AGE_W-1:0]        cmp_age_o,
  output logic                           le_o,
  output logic signed [SAMPLE_WIDTH-1:0] next_val_o
);

  logic signed [SAMPLE_WIDTH-1:0] value_q, value_d;
  logic        [AGE_W-1:0]        age_q, age_d;

  // This cell holds the oldest entry of a full window.
  assign del_o = ctl_i.full && ctl_i.valid && (age_q == oldest_age_i);

  // Contents after the oldest entry has been squeezed out.
  assign cmp_val_o = ctl_i.shift ? right_val_i : value_q;
  assign cmp_age_o = ctl_i.shift ? right_age_i : age_q;

  // Entries not above the new sample stay ahead of it (older equal values first).
  assign le_o = ctl_i.valid_c && (cmp_val_o <= sample_i);

  // Keep, take the new sample, or take the left neighbor's entry.
  always_comb begin
    if (le_o) begin
      value_d = cmp_val_o;
      age_d   = cmp_age_o + AGE_W'(1);
    end else if (ctl_i.first || left_le_i) begin
      value_d = sample_i;
      age_d   = '0;
    end else begin
      value_d = left_val_i;
      age_d   = left_age_i + AGE_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      value_q <= value_d;
      age_q   <= age_d;
    end
  end

  assign value_o    = value_q;
  assign age_o      = age_q;
  assign next_val_o = value_d;

endmodule
